FILE: src/gravity_feedforward_current_assert.svh
// assertion macros for the gravity feed-forward control module
`ifndef GRAVITY_FEEDFORWARD_CURRENT_ASSERT_SVH
`define GRAVITY_FEEDFORWARD_CURRENT_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define GFC_ASSERT_IMPL(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// next-cycle implication
`define GFC_ASSERT_NEXT(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

FILE: src/gfc_pkg.sv
// shared types, constants and tables for the gravity feed-forward block
package gfc_pkg;
   localparam int ANGLE_WIDTH_DEF  = 16;
   localparam int COSINE_STEPS_DEF = 14;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_ANGLE_ALPHA   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CURRENT_ALPHA = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRAV_MAX      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIXED_OFFSET  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEAD_ZONE     = 3'd4;

   localparam logic signed [31:0] Q28_ONE     = 32'sd268435456;
   localparam logic signed [31:0] Q28_PI      = 32'sd843314857;
   localparam logic signed [31:0] Q28_HALF_PI = 32'sd421657428;
   localparam logic signed [31:0] Q28_GAIN    = 32'sd163008219;

   // step commands from controller to datapath
   typedef struct packed {
      logic load;      // capture input and compute filtered angle
      logic prep;      // fold angle and start rotation
      logic rotate;    // one rotation step
      logic grav_mul;  // max times cosine
      logic corr;      // error and correction
      logic cur_mul;   // current filter products
      logic finish;    // commit state and output
   } cmd_type;

   function automatic logic signed [31:0] atan_q28(input logic [4:0] i);
      case (i)
         5'd0: atan_q28 = 32'sd210828714;
         5'd1: atan_q28 = 32'sd124459457;
         5'd2: atan_q28 = 32'sd65760959;
         5'd3: atan_q28 = 32'sd33381290;
         5'd4: atan_q28 = 32'sd16755421;
         5'd5: atan_q28 = 32'sd8385879;
         5'd6: atan_q28 = 32'sd4193963;
         5'd7: atan_q28 = 32'sd2097109;
         5'd8: atan_q28 = 32'sd1048571;
         5'd9: atan_q28 = 32'sd524287;
         5'd10: atan_q28 = 32'sd262144;
         5'd11: atan_q28 = 32'sd131072;
         5'd12: atan_q28 = 32'sd65536;
         5'd13: atan_q28 = 32'sd32768;
         5'd14: atan_q28 = 32'sd16384;
         5'd15: atan_q28 = 32'sd8192;
         5'd16: atan_q28 = 32'sd4096;
         5'd17: atan_q28 = 32'sd2048;
         5'd18: atan_q28 = 32'sd1024;
         5'd19: atan_q28 = 32'sd512;
         default: atan_q28 = 32'sd0;
      endcase
   endfunction
endpackage

FILE: src/gfc_stream_if.sv
// valid/ready stream interface carrying one payload
interface gfc_stream_if #(parameter int W = 16) ();
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: src/gfc_ctrl.sv
// sequencing state machine for one sample
module gfc_ctrl import gfc_pkg::*; #(
   parameter int COSINE_STEPS = COSINE_STEPS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   output logic    out_valid,
   input  logic    out_ready,
   output cmd_type cmd,
   output logic [4:0] step_idx
);
`include "gravity_feedforward_current_assert.svh"
   typedef enum logic [7:0] {
      S_IDLE = 8'b00000001, S_PREP = 8'b00000010, S_ROT  = 8'b00000100,
      S_GMUL = 8'b00001000, S_CORR = 8'b00010000, S_CMUL = 8'b00100000,
      S_FIN  = 8'b01000000, S_OUT  = 8'b10000000
   } state_type;

   state_type  state_ff, state_in;
   logic [4:0] step_ff, step_in;

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         S_IDLE: if (in_valid) state_in = S_PREP;
         S_PREP: begin state_in = S_ROT; step_in = 5'd0; end
         S_ROT: begin
            if (step_ff == 5'(COSINE_STEPS - 1)) state_in = S_GMUL;
            else step_in = step_ff + 5'd1;
         end
         S_GMUL: state_in = S_CORR;
         S_CORR: state_in = S_CMUL;
         S_CMUL: state_in = S_FIN;
         S_FIN:  state_in = S_OUT;
         S_OUT:  if (out_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= 5'd0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   assign in_ready     = (state_ff == S_IDLE);
   assign out_valid    = (state_ff == S_OUT);
   assign step_idx     = step_ff;
   assign cmd.load     = in_ready && in_valid;
   assign cmd.prep     = (state_ff == S_PREP);
   assign cmd.rotate   = (state_ff == S_ROT);
   assign cmd.grav_mul = (state_ff == S_GMUL);
   assign cmd.corr     = (state_ff == S_CORR);
   assign cmd.cur_mul  = (state_ff == S_CMUL);
   assign cmd.finish   = (state_ff == S_FIN);

   `GFC_ASSERT_IMPL(a_onehot, clock, reset, 1'b1, $onehot(state_ff), "state not one-hot")
   `GFC_ASSERT_NEXT(a_load_prep, clock, reset, cmd.load, state_ff == S_PREP, "load not followed by prep")
   `GFC_ASSERT_NEXT(a_fin_out, clock, reset, cmd.finish, out_valid, "finish not followed by result")
   `GFC_ASSERT_IMPL(a_step_rng, clock, reset, cmd.rotate, step_ff < 5'(COSINE_STEPS), "rotation step out of range")
endmodule

FILE: src/gfc_datapath.sv
// arithmetic for one sample: filters, cordic cosine, correction
module gfc_datapath import gfc_pkg::*; #(
   parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   input  logic [4:0]         step_idx,
   input  logic               csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic signed [15:0] angle_in,
   output logic signed [15:0] cmd_out,
   output logic signed [15:0] filt_out
);
   localparam int AF = (ANGLE_WIDTH > 16) ? 16 : ANGLE_WIDTH;

   logic [15:0] a_alpha_ff, c_alpha_ff, dz_pad;
   logic [14:0] gmax_ff;
   logic signed [14:0] offs_ff;
   logic [11:0] dz_ff;
   logic signed [31:0] asm_ff, csm_ff, ht_ff;
   logic signed [15:0] filt_ff, cmd_ff;
   logic signed [31:0] x_ff, y_ff, z_ff;
   logic neg_ff;
   logic signed [31:0] grav_ff, sum_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         a_alpha_ff <= 16'd32768; c_alpha_ff <= 16'd32768;
         gmax_ff <= '0; offs_ff <= '0; dz_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_ANGLE_ALPHA:   a_alpha_ff <= csr_data;
            CSR_CURRENT_ALPHA: c_alpha_ff <= csr_data;
            CSR_GRAV_MAX:      gmax_ff <= csr_data[14:0];
            CSR_FIXED_OFFSET:  offs_ff <= csr_data[14:0];
            CSR_DEAD_ZONE:     dz_ff <= csr_data[11:0];
            default: ;
         endcase
      end
   end
   assign dz_pad = {4'd0, dz_ff};

   // angle filter
   logic signed [50:0] asum;
   logic signed [34:0] asm_new;
   always_comb begin
      asum = $signed({1'b0, a_alpha_ff}) * 51'(angle_in * (32'sd1 <<< AF))
           + $signed({1'b0, 17'(17'd65536 - {1'b0, a_alpha_ff})}) * 51'(asm_ff);
      asm_new = 35'(asum >>> 16);
   end

   // wrap into [-pi, pi], then fold into [-pi/2, pi/2]
   // the angle spans under three pi, so one wrap step each way is enough
   logic signed [32:0] z0, zr, z1;
   logic n1;
   always_comb begin
      z0 = 33'(filt_ff) <<< 16;
      zr = z0;
      if (zr > 33'(Q28_PI)) zr = zr - 33'(Q28_PI) - 33'(Q28_PI);
      if (zr < -33'(Q28_PI)) zr = zr + 33'(Q28_PI) + 33'(Q28_PI);
      z1 = zr; n1 = 1'b0;
      if (zr > 33'(Q28_HALF_PI)) begin z1 = 33'(Q28_PI) - zr; n1 = 1'b1; end
      else if (zr < -33'(Q28_HALF_PI)) begin z1 = -33'(Q28_PI) - zr; n1 = 1'b1; end
   end

   // one cordic rotation
   logic signed [31:0] dx, dy, at;
   assign dx = y_ff >>> step_idx;
   assign dy = x_ff >>> step_idx;
   assign at = atan_q28(step_idx);

   // gravity product and correction
   logic signed [31:0] cosv, err, mag, corr, gm, g2;
   logic signed [47:0] gprod;
   logic signed [39:0] ctmp;
   always_comb begin
      cosv = (x_ff > Q28_ONE) ? Q28_ONE : ((x_ff < -Q28_ONE) ? -Q28_ONE : x_ff);
      if (neg_ff) cosv = -cosv;
      gprod = 48'($signed({1'b0, gmax_ff})) * 48'(cosv) + 48'sd134217728;
      err  = ht_ff - 32'(filt_ff);
      mag  = (err < 0) ? -err : err;
      gm   = 32'($signed({1'b0, gmax_ff}));
      ctmp = (40'(err) * 40'sd50 + 40'sd2048) >>> 12;
      corr = (ctmp > 40'(gm)) ? gm : ((ctmp < -40'(gm)) ? -gm : 32'(ctmp));
      g2   = grav_ff + ((mag > 32'(dz_pad)) ? corr : 32'sd0);
   end

   // current filter
   logic signed [54:0] csum;
   logic signed [38:0] csm_new;
   always_comb begin
      csum = $signed({1'b0, c_alpha_ff}) * 55'(sum_ff <<< 15)
           + $signed({1'b0, 17'(17'd65536 - {1'b0, c_alpha_ff})}) * 55'(csm_ff);
      csm_new = 39'(csum >>> 16);
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         asm_ff <= '0; ht_ff <= '0; csm_ff <= '0;
      end else begin
         if (cmd.load) begin
            asm_ff  <= 32'(asm_new);
            filt_ff <= 16'(asm_new >>> AF);
         end
         if (cmd.prep) begin
            x_ff <= Q28_GAIN; y_ff <= '0; z_ff <= 32'(z1); neg_ff <= n1;
         end
         if (cmd.rotate) begin
            if (!z_ff[31]) begin
               x_ff <= x_ff - dx; y_ff <= y_ff + dy; z_ff <= z_ff - at;
            end else begin
               x_ff <= x_ff + dx; y_ff <= y_ff - dy; z_ff <= z_ff + at;
            end
         end
         if (cmd.grav_mul)
            grav_ff <= 32'(gprod >>> 28) + 32'(offs_ff);
         if (cmd.corr) begin
            sum_ff <= (g2 > 32'sd65535) ? 32'sd65535 : ((g2 < -32'sd65535) ? -32'sd65535 : g2);
            if (mag > 32'(dz_pad) * 3) ht_ff <= 32'(filt_ff);
         end
         if (cmd.cur_mul) csm_ff <= 32'(csm_new);
         if (cmd.finish) begin
            cmd_ff <= ((csm_ff >>> 15) > 32'sd32767) ? 16'sd32767 :
                      (((csm_ff >>> 15) < -32'sd32768) ? -16'sd32768 : 16'(csm_ff >>> 15));
         end
      end
   end

   assign cmd_out  = cmd_ff;
   assign filt_out = filt_ff;
endmodule

FILE: src/gravity_feedforward_current.sv
// gravity feed-forward current: top level
// Usage: the req channel carries one encoder angle (signed Q3.12) per control
// tick; the rsp channel returns the smoothed current command and the filtered
// angle for that tick. csr_write with csr_index 0..4 sets angle alpha, current
// alpha, peak gravity current, fixed offset and dead zone; other indexes are
// ignored. Write registers only while idle.
// Sequence: after accept the angle is folded, the cordic rotates one step per
// cycle, then the gravity product, correction, current filter and result follow.
// Only one sample is in flight; the next beat is taken the cycle after the
// result beat leaves. Reset clears the filters, the held target and the
// configuration registers to their defaults. When the receiver stalls, the
// result holds and req_ready stays low until the result beat is taken.
module gravity_feedforward_current import gfc_pkg::*; #(
   parameter int ANGLE_WIDTH  = ANGLE_WIDTH_DEF,
   parameter int COSINE_STEPS = COSINE_STEPS_DEF
) (
   input  logic clock,
   input  logic reset,
   gfc_stream_if.sink   req,
   gfc_stream_if.source rsp,
   input  logic csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);
   cmd_type    cmd;
   logic [4:0] step_idx;
   logic signed [15:0] cmd_out, filt_out;

   gfc_ctrl #(.COSINE_STEPS(COSINE_STEPS)) u_ctrl (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready),
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .cmd, .step_idx
   );

   gfc_datapath #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_dp (
      .clock, .reset, .cmd, .step_idx,
      .csr_write, .csr_index, .csr_data,
      .angle_in(req.data[15:0]),
      .cmd_out, .filt_out
   );

   assign rsp.data = {filt_out, cmd_out};
endmodule

FILE: bench/tb_gravity_feedforward_current.sv
// testbench for the gravity feed-forward current block: random and directed angles checked
`timescale 1ns / 1ps

module tb_gravity_feedforward_current;
   import gfc_pkg::*;

   typedef struct {
      logic [15:0] angle;
      bit          drain;   // sender holds off until all results are in
   } angle_beat_t;

   typedef struct {
      logic [15:0] command;
      logic [15:0] angle;
   } tick_result_t;

   logic clock;
   logic reset;
   logic csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   gfc_stream_if #(.W(16)) req_if ();
   gfc_stream_if #(.W(32)) rsp_if ();

   gravity_feedforward_current dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // predictor copy of the registers and filter state
   longint angle_alpha_m, current_alpha_m, grav_max_m, offset_m, dead_zone_m;
   longint angle_filter_m, held_target_m, current_filter_m;
   longint atan_table [20] = '{
      210828714, 124459457, 65760959, 33381290, 16755421,
      8385879, 4193963, 2097109, 1048571, 524287,
      262144, 131072, 65536, 32768, 16384,
      8192, 4096, 2048, 1024, 512};

   angle_beat_t  pending_angles[$];
   tick_result_t expected_ticks[$];
   int  mismatches;
   bit  idling_on;
   int  send_gap;
   int  recv_stall;
   int  walk_angle;

   function automatic longint clamp(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // cosine in Q.28 of a Q3.12 angle
   function automatic longint cosine_of(longint a);
      longint z, x, y, dx, dy;
      bit flip;
      z = a * 65536;
      x = Q28_GAIN;
      y = 0;
      flip = 0;
      if (z > Q28_PI) z -= 2 * Q28_PI;
      if (z > Q28_PI) z -= 2 * Q28_PI;
      if (z < -Q28_PI) z += 2 * Q28_PI;
      if (z < -Q28_PI) z += 2 * Q28_PI;
      if (z > Q28_HALF_PI) begin
         z = Q28_PI - z;
         flip = 1;
      end else if (z < -Q28_HALF_PI) begin
         z = -Q28_PI - z;
         flip = 1;
      end
      for (int i = 0; i < COSINE_STEPS_DEF && i < 20; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx;
            y += dy;
            z -= atan_table[i];
         end else begin
            x += dx;
            y -= dy;
            z += atan_table[i];
         end
      end
      x = clamp(x, -Q28_ONE, Q28_ONE);
      return flip ? -x : x;
   endfunction

   // one control tick of the feed-forward law
   function automatic void predict_tick(logic [15:0] raw);
      longint filt, grav, err, mag, corr, total, cmd;
      tick_result_t r;
      angle_filter_m = (angle_alpha_m * (longint'($signed(raw)) <<< 16)
                        + (65536 - angle_alpha_m) * angle_filter_m) >>> 16;
      filt = angle_filter_m >>> 16;
      grav = ((grav_max_m * cosine_of(filt) + (longint'(1) <<< 27)) >>> 28) + offset_m;
      err  = held_target_m - filt;
      mag  = (err < 0) ? -err : err;
      corr = 0;
      if (mag > 3 * dead_zone_m) held_target_m = filt;
      if (mag > dead_zone_m)
         corr = clamp((50 * err + 2048) >>> 12, -grav_max_m, grav_max_m);
      total = clamp(grav + corr, -65535, 65535);
      current_filter_m = (current_alpha_m * (total <<< 15)
                          + (65536 - current_alpha_m) * current_filter_m) >>> 16;
      cmd = clamp(current_filter_m >>> 15, -32768, 32767);
      r.command = cmd[15:0];
      r.angle   = filt[15:0];
      expected_ticks.push_back(r);
   endfunction

   // angle driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.data  <= '0;
         send_gap = 0;
      end else begin
         if (req_if.valid && req_if.ready) predict_tick(req_if.data);
         if (!req_if.valid || req_if.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_if.valid <= 1'b0;
            end else if (pending_angles.size() > 0 &&
                         !(pending_angles[0].drain && expected_ticks.size() > 0)) begin
               req_if.valid <= 1'b1;
               req_if.data  <= pending_angles[0].angle;
               void'(pending_angles.pop_front());
               send_gap = idling_on ? $urandom_range(0, 9) : 0;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         recv_stall = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_ticks.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result beat %h", rsp_if.data);
            end else begin
               tick_result_t e;
               e = expected_ticks.pop_front();
               if (rsp_if.data[15:0] !== e.command || rsp_if.data[31:16] !== e.angle) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: command exp %0d got %0d, angle exp %0d got %0d",
                              $signed(e.command), $signed(rsp_if.data[15:0]),
                              $signed(e.angle), $signed(rsp_if.data[31:16]));
               end
            end
            recv_stall = idling_on ? $urandom_range(0, 9) : 0;
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [15:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      case (idx)
         CSR_ANGLE_ALPHA:   angle_alpha_m   = val;
         CSR_CURRENT_ALPHA: current_alpha_m = val;
         CSR_GRAV_MAX:      grav_max_m      = val[14:0];
         CSR_FIXED_OFFSET:  offset_m        = longint'($signed(val[14:0]));
         CSR_DEAD_ZONE:     dead_zone_m     = val[11:0];
         default: ;
      endcase
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // wait for the block to go idle, then past its latency
   task automatic wait_idle();
      while (pending_angles.size() > 0 || req_if.valid || expected_ticks.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic queue_angle(logic [15:0] a, bit drain);
      angle_beat_t b;
      b.angle = a;
      b.drain = drain;
      pending_angles.push_back(b);
   endtask

   // mostly a slow random walk so the dead zone logic is exercised, some jumps
   task automatic queue_random(int count, bit drain);
      int pick;
      repeat (count) begin
         pick = $urandom_range(0, 9);
         if (pick < 6)
            walk_angle = int'(clamp(walk_angle + int'($urandom_range(0, 600)) - 300,
                                    -32768, 32767));
         else if (pick == 9)
            walk_angle = $signed(16'($urandom));
         queue_angle(walk_angle[15:0], drain);
      end
   endtask

   function automatic logic [15:0] pick_extreme(logic [15:0] lo, logic [15:0] hi);
      int p;
      p = $urandom_range(0, 3);
      if (p == 0) return lo;
      if (p == 1) return hi;
      return 16'($urandom);
   endfunction

   initial begin
      reset     = 1'b1;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      req_if.valid = 1'b0;
      req_if.data  = '0;
      rsp_if.ready = 1'b0;
      mismatches = 0;
      idling_on  = 1;
      walk_angle = 0;
      angle_alpha_m = 32768;
      current_alpha_m = 32768;
      grav_max_m = 0;
      offset_m = 0;
      dead_zone_m = 0;
      angle_filter_m = 0;
      held_target_m = 0;
      current_filter_m = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: reset defaults, then extremes of angle with full weight
      queue_angle(16'h7fff, 0);
      queue_angle(16'h8000, 0);
      queue_angle(16'h0000, 0);
      wait_idle();
      write_reg(CSR_ANGLE_ALPHA, 16'hffff);
      write_reg(CSR_CURRENT_ALPHA, 16'hffff);
      write_reg(CSR_GRAV_MAX, 16'd16384);
      write_reg(CSR_FIXED_OFFSET, 16'h3fff);
      write_reg(CSR_DEAD_ZONE, 16'd0);
      write_reg(3'd5, 16'hffff);
      write_reg(3'd7, 16'h1234);
      foreach (atan_table[i]) begin
         if (i < 12) queue_angle(16'(i * 2731 - 16384), 0);
      end
      queue_angle(16'h7fff, 0);
      queue_angle(16'h8000, 0);
      queue_angle(16'h0001, 0);
      queue_angle(16'hffff, 0);
      wait_idle();
      // out of range register bits, zero angle weight, saturating sum
      write_reg(CSR_GRAV_MAX, 16'hffff);
      write_reg(CSR_FIXED_OFFSET, 16'h4000);
      write_reg(CSR_DEAD_ZONE, 16'hffff);
      write_reg(CSR_ANGLE_ALPHA, 16'h0000);
      queue_angle(16'h7fff, 0);
      queue_angle(16'h8000, 0);
      wait_idle();

      // random phases with fresh settings
      for (int ph = 0; ph < 9; ph++) begin
         write_reg(CSR_ANGLE_ALPHA, pick_extreme(16'h0000, 16'hffff));
         write_reg(CSR_CURRENT_ALPHA, pick_extreme(16'h0000, 16'hffff));
         write_reg(CSR_GRAV_MAX, pick_extreme(16'd0, 16'd16384));
         write_reg(CSR_FIXED_OFFSET, pick_extreme(16'hc000, 16'h3fff));
         write_reg(CSR_DEAD_ZONE, ($urandom_range(0, 2) == 0) ? pick_extreme(16'd0, 16'd4095)
                                                              : 16'($urandom_range(0, 200)));
         idling_on = (ph % 3 != 1);
         queue_random(145, ph == 4);
         wait_idle();
      end

      if (mismatches == 0) begin
         $display("tb_gravity_feedforward_current passed");
      end else begin
         $display("tb_gravity_feedforward_current failed");
      end
      $finish;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("tb_gravity_feedforward_current failed");
      $finish;
   end
endmodule
